// ===== sv/drd_pkg.sv =====
`timescale 1ns / 1ps
// Package for the detection row decoder: field widths, row layout constants
// and configuration register indexes. No dependencies.
package drd_pkg;

  // Field widths.
  localparam int ElemW    = 16;
  localparam int CoordW   = 19;
  localparam int ClassW   = 6;
  localparam int ScoreW   = 16;
  localparam int ScaleW   = 14;
  localparam int LenW     = 7;
  localparam int MaskW    = 64;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 64;

  // Signed corner product: coordinate sum times the zero-extended scale.
  localparam int ProdW    = CoordW + ScaleW + 1;
  // Coordinates are in 1/16 pixel, so the Q0.16 product drops 13 bits.
  localparam int CoordShift = 13;

  // Row layout.
  localparam logic [LenW-1:0] BoxFields = 7'd4;
  localparam logic [LenW-1:0] ConfPos   = 7'd4;
  localparam logic [LenW-1:0] ClassBase = 7'd5;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegConfThreshold = 3'd0;
  localparam logic [CfgIdxW-1:0] RegImageWidth    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegImageHeight   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegRowLength     = 3'd3;
  localparam logic [CfgIdxW-1:0] RegFilterEnable  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegClassMask     = 3'd5;

  // Reset values of the registers.
  localparam logic [ScaleW-1:0] ImageSizeReset = 14'd640;
  localparam logic [LenW-1:0]   RowLengthReset = 7'd6;

endpackage

// ===== sv/drd_if.sv =====
`timescale 1ns / 1ps
// Stream interfaces of the detection row decoder: row elements in, detections out.
// Depends on drd_pkg for the field widths.
interface drd_elem_if;
  logic                          valid;
  logic                          ready;
  logic [drd_pkg::ElemW-1:0]     element;

  modport source (output valid, output element, input ready);
  modport sink   (input valid, input element, output ready);
  modport monitor (input valid, input element, input ready);
endinterface

interface drd_det_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [drd_pkg::CoordW-1:0]    left;
  logic signed [drd_pkg::CoordW-1:0]    top;
  logic signed [drd_pkg::CoordW-1:0]    right;
  logic signed [drd_pkg::CoordW-1:0]    bottom;
  logic        [drd_pkg::ClassW-1:0]    cls_idx;
  logic        [drd_pkg::ScoreW-1:0]    score;

  modport source (output valid, output left, output top, output right, output bottom,
                  output cls_idx, output score, input ready);
  modport sink   (input valid, input left, input top, input right, input bottom,
                  input cls_idx, input score, output ready);
  modport monitor (input valid, input left, input top, input right, input bottom,
                   input cls_idx, input score, input ready);
endinterface

// ===== sv/detection_row_decode_top.sv =====
`timescale 1ns / 1ps
// Top level of the detection row decoder: row element stream in, detection stream out.
// Depends on drd_pkg and on the interfaces in drd_if.sv.
//
//   channel   direction  word                                       handshake
//   elem_i    in         element (Q0.16)                            valid / ready
//   det_o     out        left, top, right, bottom, cls_idx, score   valid / ready
//   cfg       in         cfg_index_i, cfg_data_i                    cfg_we_i, no wait
//
// One element word is taken per cycle. The row state (box fields, confidence and the
// running class argmax) is updated in the cycle of acceptance. The last element of a row
// starts a three-stage pass: corner sums, then the five multipliers (score and four
// corners), then the threshold test into the output register. A stalled output holds
// its word; the two stages behind it keep filling, and the input stalls only when all
// of them are occupied. Reset clears row state, stage valid bits and the configuration
// registers to their defaults.
module detection_row_decode_top #(
  parameter int MAX_CLASSES = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [drd_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [drd_pkg::CfgDataW-1:0]   cfg_data_i,
  drd_elem_if.sink                       elem_i,
  drd_det_if.source                      det_o
);

  // Longest row: the box fields, confidence and one score per class.
  localparam logic [drd_pkg::LenW-1:0] LenMax =
    drd_pkg::LenW'(int'(drd_pkg::ClassBase) + MAX_CLASSES);

  // ------------------------------------------------------------------
  // Configuration registers.
  // ------------------------------------------------------------------
  logic [drd_pkg::ScoreW-1:0] thr_q;
  logic [drd_pkg::ScaleW-1:0] img_w_q;
  logic [drd_pkg::ScaleW-1:0] img_h_q;
  logic [drd_pkg::LenW-1:0]   row_len_q;
  logic                       filt_en_q;
  logic [drd_pkg::MaskW-1:0]  class_mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q        <= '0;
      img_w_q      <= drd_pkg::ImageSizeReset;
      img_h_q      <= drd_pkg::ImageSizeReset;
      row_len_q    <= drd_pkg::RowLengthReset;
      filt_en_q    <= 1'b0;
      class_mask_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        drd_pkg::RegConfThreshold: thr_q        <= cfg_data_i[drd_pkg::ScoreW-1:0];
        drd_pkg::RegImageWidth:    img_w_q      <= cfg_data_i[drd_pkg::ScaleW-1:0];
        drd_pkg::RegImageHeight:   img_h_q      <= cfg_data_i[drd_pkg::ScaleW-1:0];
        drd_pkg::RegRowLength:     row_len_q    <= cfg_data_i[drd_pkg::LenW-1:0];
        drd_pkg::RegFilterEnable:  filt_en_q    <= cfg_data_i[0];
        drd_pkg::RegClassMask:     class_mask_q <= cfg_data_i[drd_pkg::MaskW-1:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------------
  // Handshake chain. Each stage may load when it is empty or when the
  // stage after it takes its contents in the same cycle.
  // ------------------------------------------------------------------
  logic s1_valid_q, s2_valid_q, out_valid_q;
  logic out_free, s2_ready, s1_ready, accept;

  assign out_free     = !out_valid_q || det_o.ready;
  assign s2_ready     = !s2_valid_q || out_free;
  assign s1_ready     = !s1_valid_q || s2_ready;
  assign elem_i.ready = s1_ready;
  assign accept       = elem_i.valid && s1_ready;

  // ------------------------------------------------------------------
  // Row state and element decode.
  // ------------------------------------------------------------------
  logic [drd_pkg::LenW-1:0]   idx_q;
  logic [drd_pkg::ElemW-1:0]  box_q [4];
  logic [drd_pkg::ElemW-1:0]  obj_q;
  logic [drd_pkg::ElemW-1:0]  best_q;
  logic [drd_pkg::ClassW-1:0] best_idx_q;

  logic [drd_pkg::LenW-1:0]   len_eff;
  logic [drd_pkg::LenW:0]     idx_inc;
  logic                       is_last;
  logic                       is_class;
  logic [drd_pkg::LenW-1:0]   class_pos;
  logic                       take;
  logic [drd_pkg::ElemW-1:0]  obj_d;
  logic [drd_pkg::ElemW-1:0]  best_d;
  logic [drd_pkg::ClassW-1:0] best_idx_d;

  always_comb begin
    // A length outside the legal range is clamped to it.
    if (row_len_q < drd_pkg::ClassBase) begin
      len_eff = drd_pkg::ClassBase;
    end else if (row_len_q > LenMax) begin
      len_eff = LenMax;
    end else begin
      len_eff = row_len_q;
    end
    idx_inc   = {1'b0, idx_q} + 8'd1;
    // A length shortened mid-row ends the row at the first element past the new end.
    is_last   = !(idx_inc < {1'b0, len_eff});
    is_class  = (idx_q >= drd_pkg::ClassBase) && (idx_q < LenMax);
    class_pos = idx_q - drd_pkg::ClassBase;
    // Strict compare, so the earliest maximum keeps the class.
    take       = is_class && (elem_i.element > best_q);
    best_d     = take ? elem_i.element : best_q;
    best_idx_d = take ? class_pos[drd_pkg::ClassW-1:0] : best_idx_q;
    obj_d      = (idx_q == drd_pkg::ConfPos) ? elem_i.element : obj_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= '0;
      box_q[0]   <= '0;
      box_q[1]   <= '0;
      box_q[2]   <= '0;
      box_q[3]   <= '0;
      obj_q      <= '0;
      best_q     <= '0;
      best_idx_q <= '0;
    end else if (accept) begin
      if (idx_q < drd_pkg::BoxFields) begin
        box_q[idx_q[1:0]] <= elem_i.element;
      end
      obj_q <= obj_d;
      if (is_last) begin
        idx_q      <= '0;
        best_q     <= '0;
        best_idx_q <= '0;
      end else begin
        idx_q      <= idx_inc[drd_pkg::LenW-1:0];
        best_q     <= best_d;
        best_idx_q <= best_idx_d;
      end
    end
  end

  // ------------------------------------------------------------------
  // Stage 1: corner sums of the finished row. The box fields are always
  // stored by the time a row ends, since every row has at least five elements.
  // ------------------------------------------------------------------
  logic signed [drd_pkg::CoordW-1:0] s1_xl_q, s1_xr_q, s1_yt_q, s1_yb_q;
  logic [drd_pkg::ElemW-1:0]         s1_obj_q, s1_best_q;
  logic [drd_pkg::ClassW-1:0]        s1_cls_q;
  logic signed [drd_pkg::CoordW-1:0] cx2, cy2, w_s, h_s;
  logic                              s1_load;

  assign s1_load = accept && is_last;
  assign cx2 = $signed({2'b00, box_q[0], 1'b0});
  assign cy2 = $signed({2'b00, box_q[1], 1'b0});
  assign w_s = $signed({3'b000, box_q[2]});
  assign h_s = $signed({3'b000, box_q[3]});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_load) begin
      s1_valid_q <= 1'b1;
    end else if (s2_ready) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_xl_q   <= cx2 - w_s;
      s1_xr_q   <= cx2 + w_s;
      s1_yt_q   <= cy2 - h_s;
      s1_yb_q   <= cy2 + h_s;
      s1_obj_q  <= obj_d;
      s1_best_q <= best_d;
      s1_cls_q  <= best_idx_d;
    end
  end

  // ------------------------------------------------------------------
  // Stage 2: the score product and the four scaled corners, plus the
  // confidence and class filter tests.
  // ------------------------------------------------------------------
  logic signed [drd_pkg::ProdW-1:0]  s2_l_q, s2_r_q, s2_t_q, s2_b_q;
  logic [2*drd_pkg::ElemW-1:0]       s2_prod_q;
  logic                              s2_obj_ok_q, s2_cls_ok_q;
  logic [drd_pkg::ClassW-1:0]        s2_cls_q;
  logic signed [drd_pkg::ScaleW:0]   sc_w, sc_h;

  assign sc_w = $signed({1'b0, img_w_q});
  assign sc_h = $signed({1'b0, img_h_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      s2_l_q      <= s1_xl_q * sc_w;
      s2_r_q      <= s1_xr_q * sc_w;
      s2_t_q      <= s1_yt_q * sc_h;
      s2_b_q      <= s1_yb_q * sc_h;
      s2_prod_q   <= s1_obj_q * s1_best_q;
      s2_obj_ok_q <= s1_obj_q >= thr_q;
      s2_cls_ok_q <= !filt_en_q || class_mask_q[s1_cls_q];
      s2_cls_q    <= s1_cls_q;
    end
  end

  // ------------------------------------------------------------------
  // Stage 3: score threshold and the output register. A row that fails
  // a test leaves the pipeline here without a word.
  // ------------------------------------------------------------------
  logic [drd_pkg::ScoreW-1:0] s2_score;
  logic                       emit;

  assign s2_score = s2_prod_q[2*drd_pkg::ElemW-1:drd_pkg::ElemW];
  assign emit = s2_valid_q && s2_obj_ok_q && s2_cls_ok_q && (s2_score >= thr_q);

  logic signed [drd_pkg::CoordW-1:0] left_q, top_q, right_q, bottom_q;
  logic [drd_pkg::ClassW-1:0]        cls_q;
  logic [drd_pkg::ScoreW-1:0]        score_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= emit;
    end
  end

  // The arithmetic shift of the product rounds toward minus infinity.
  always_ff @(posedge clk_i) begin
    if (out_free && emit) begin
      left_q   <= s2_l_q[drd_pkg::CoordShift +: drd_pkg::CoordW];
      right_q  <= s2_r_q[drd_pkg::CoordShift +: drd_pkg::CoordW];
      top_q    <= s2_t_q[drd_pkg::CoordShift +: drd_pkg::CoordW];
      bottom_q <= s2_b_q[drd_pkg::CoordShift +: drd_pkg::CoordW];
      cls_q    <= s2_cls_q;
      score_q  <= s2_score;
    end
  end

  assign det_o.valid   = out_valid_q;
  assign det_o.left    = left_q;
  assign det_o.top     = top_q;
  assign det_o.right   = right_q;
  assign det_o.bottom  = bottom_q;
  assign det_o.cls_idx = cls_q;
  assign det_o.score   = score_q;

endmodule

// ===== sv/drd_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the detection row decoder, bound to its top level.
// Depends on drd_pkg; the bind also relies on detection_row_decode_top.
module drd_checker #(
  parameter int MAX_CLASSES = 64
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              elem_ready_i,
  input logic                              det_valid_i,
  input logic                              det_ready_i,
  input logic signed [drd_pkg::CoordW-1:0] det_left_i,
  input logic signed [drd_pkg::CoordW-1:0] det_top_i,
  input logic signed [drd_pkg::CoordW-1:0] det_right_i,
  input logic signed [drd_pkg::CoordW-1:0] det_bottom_i,
  input logic [drd_pkg::ClassW-1:0]        det_cls_idx_i,
  input logic [drd_pkg::ScoreW-1:0]        det_score_i
);

  // A stalled detection keeps its word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    det_valid_i && !det_ready_i |=> det_valid_i && $stable(det_left_i) &&
      $stable(det_top_i) && $stable(det_right_i) && $stable(det_bottom_i) &&
      $stable(det_cls_idx_i) && $stable(det_score_i))
    else $error("stalled detection changed");

  // With the output register empty, every stage behind it can move, so the input is ready.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !det_valid_i |-> elem_ready_i)
    else $error("input stalled while output is empty");

  // The class index never leaves the configured class range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    det_valid_i |-> (int'(det_cls_idx_i) < MAX_CLASSES))
    else $error("class index out of range");

  // No detection can be present in the first cycle after reset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> !det_valid_i)
    else $error("detection right after reset");

endmodule

bind detection_row_decode_top drd_checker #(.MAX_CLASSES(MAX_CLASSES)) u_drd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .elem_ready_i  (elem_i.ready),
  .det_valid_i   (det_o.valid),
  .det_ready_i   (det_o.ready),
  .det_left_i    (det_o.left),
  .det_top_i     (det_o.top),
  .det_right_i   (det_o.right),
  .det_bottom_i  (det_o.bottom),
  .det_cls_idx_i (det_o.cls_idx),
  .det_score_i   (det_o.score)
);

// ===== tb/drd_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the detection row decoder: watches the config port and both streams,
// predicts detections and compares them. Depends on drd_pkg and the interfaces in drd_if.sv.
module drd_scoreboard #(
  parameter int MAX_CLASSES = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [drd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [drd_pkg::CfgDataW-1:0] cfg_data_i,
  drd_elem_if.monitor                  elem_i,
  drd_det_if.monitor                   det_i,
  output logic [31:0]                  fail_count_o,
  output logic [31:0]                  pending_o
);

  typedef struct packed {
    logic signed [drd_pkg::CoordW-1:0] left;
    logic signed [drd_pkg::CoordW-1:0] top;
    logic signed [drd_pkg::CoordW-1:0] right;
    logic signed [drd_pkg::CoordW-1:0] bottom;
    logic [drd_pkg::ClassW-1:0]        cls_idx;
    logic [drd_pkg::ScoreW-1:0]        score;
  } det_word_t;

  // Shadow copy of the configuration registers.
  logic [drd_pkg::ScoreW-1:0] thr_q;
  logic [drd_pkg::ScaleW-1:0] width_q;
  logic [drd_pkg::ScaleW-1:0] height_q;
  logic [drd_pkg::LenW-1:0]   len_q;
  logic                       filter_q;
  logic [drd_pkg::MaskW-1:0]  mask_q;

  // Shadow copy of the row state.
  logic [drd_pkg::LenW-1:0]   row_pos_q;
  logic [drd_pkg::ElemW-1:0]  box_q [4];
  logic [drd_pkg::ElemW-1:0]  conf_q;
  logic [drd_pkg::ElemW-1:0]  best_score_q;
  logic [drd_pkg::ClassW-1:0] best_class_q;

  det_word_t expected_dets [$];
  int        fails = 0;

  // Corner from center and size, scaled and floored to 1/16 pixel.
  function automatic logic [drd_pkg::CoordW-1:0] corner_coord(
      input logic [drd_pkg::ElemW-1:0]  center,
      input logic [drd_pkg::ElemW-1:0]  extent,
      input logic [drd_pkg::ScaleW-1:0] scale,
      input bit                         far_edge);
    longint span;
    if (far_edge) span = 2 * longint'(center) + longint'(extent);
    else          span = 2 * longint'(center) - longint'(extent);
    span = (span * longint'(scale)) >>> drd_pkg::CoordShift;
    return span[drd_pkg::CoordW-1:0];
  endfunction

  task automatic decode_element(input logic [drd_pkg::ElemW-1:0] value);
    int                         eff_len;
    int                         pos;
    logic [31:0]                prod;
    logic [drd_pkg::ScoreW-1:0] det_score;
    bit                         emit;
    det_word_t                  want;
    eff_len = int'(len_q);
    if (eff_len < int'(drd_pkg::ClassBase)) eff_len = int'(drd_pkg::ClassBase);
    if (eff_len > int'(drd_pkg::ClassBase) + MAX_CLASSES) begin
      eff_len = int'(drd_pkg::ClassBase) + MAX_CLASSES;
    end
    pos = int'(row_pos_q);

    if (pos < int'(drd_pkg::BoxFields)) begin
      box_q[pos[1:0]] = value;
    end else if (pos == int'(drd_pkg::ConfPos)) begin
      conf_q = value;
    end else if (pos - int'(drd_pkg::ClassBase) < MAX_CLASSES) begin
      if (value > best_score_q) begin
        best_score_q = value;
        best_class_q = drd_pkg::ClassW'(pos - int'(drd_pkg::ClassBase));
      end
    end

    if (pos + 1 < eff_len) begin
      row_pos_q = drd_pkg::LenW'(pos + 1);
      return;
    end

    prod      = conf_q * best_score_q;
    det_score = prod[31:16];
    emit      = (conf_q >= thr_q) && (det_score >= thr_q);
    if (filter_q && !mask_q[best_class_q]) emit = 1'b0;

    if (emit) begin
      want.left    = corner_coord(box_q[0], box_q[2], width_q, 1'b0);
      want.top     = corner_coord(box_q[1], box_q[3], height_q, 1'b0);
      want.right   = corner_coord(box_q[0], box_q[2], width_q, 1'b1);
      want.bottom  = corner_coord(box_q[1], box_q[3], height_q, 1'b1);
      want.cls_idx = best_class_q;
      want.score   = det_score;
      expected_dets.insert(expected_dets.size(), want);
    end
    row_pos_q    = '0;
    best_score_q = '0;
    best_class_q = '0;
  endtask

  task automatic check_field(input string name, input logic [drd_pkg::CoordW-1:0] want_v,
                             input logic [drd_pkg::CoordW-1:0] got_v);
    if (got_v !== want_v) begin
      fails++;
      $display("%0t: %s mismatch, expected %0d, actual %0d",
               $time, name, $signed(want_v), $signed(got_v));
    end
  endtask

  task automatic check_detection();
    det_word_t want;
    if (expected_dets.size() == 0) begin
      fails++;
      $display("%0t: detection with none expected, actual l=%0d t=%0d r=%0d b=%0d c=%0d s=%0d",
               $time, det_i.left, det_i.top, det_i.right, det_i.bottom,
               det_i.cls_idx, det_i.score);
    end else begin
      want = expected_dets.pop_front();
      check_field("left", want.left, det_i.left);
      check_field("top", want.top, det_i.top);
      check_field("right", want.right, det_i.right);
      check_field("bottom", want.bottom, det_i.bottom);
      check_field("class", drd_pkg::CoordW'(want.cls_idx), drd_pkg::CoordW'(det_i.cls_idx));
      check_field("score", drd_pkg::CoordW'(want.score), drd_pkg::CoordW'(det_i.score));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q        = '0;
      width_q      = drd_pkg::ImageSizeReset;
      height_q     = drd_pkg::ImageSizeReset;
      len_q        = drd_pkg::RowLengthReset;
      filter_q     = 1'b0;
      mask_q       = '0;
      row_pos_q    = '0;
      for (int i = 0; i < 4; i++) box_q[i] = '0;
      conf_q       = '0;
      best_score_q = '0;
      best_class_q = '0;
      expected_dets.delete();
      pending_o    <= '0;
      fail_count_o <= 32'(fails);
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          drd_pkg::RegConfThreshold: thr_q    = cfg_data_i[drd_pkg::ScoreW-1:0];
          drd_pkg::RegImageWidth:    width_q  = cfg_data_i[drd_pkg::ScaleW-1:0];
          drd_pkg::RegImageHeight:   height_q = cfg_data_i[drd_pkg::ScaleW-1:0];
          drd_pkg::RegRowLength:     len_q    = cfg_data_i[drd_pkg::LenW-1:0];
          drd_pkg::RegFilterEnable:  filter_q = cfg_data_i[0];
          drd_pkg::RegClassMask:     mask_q   = cfg_data_i[drd_pkg::MaskW-1:0];
          default: ;
        endcase
      end
      // A detection leaving now always belongs to an earlier row, so compare first.
      if (det_i.valid && det_i.ready) check_detection();
      if (elem_i.valid && elem_i.ready) decode_element(elem_i.element);
      pending_o    <= 32'(expected_dets.size());
      fail_count_o <= 32'(fails);
    end
  end

endmodule

// ===== tb/tb_detection_row_decode_top.sv =====
`timescale 1ns / 1ps
// Testbench top for the detection row decoder: clock, reset, config writes, element
// stimulus, output back-pressure and the verdict. Depends on drd_pkg, drd_if.sv, drd_scoreboard.
module tb_detection_row_decode_top;

  // Cycles without any handshake or config write before the run is declared hung.
  localparam int IdleLimit   = 1000;
  // The decoder has a three-stage back end; rows that emit nothing still pass through it,
  // so after the last expected word we give it extra cycles to drain before touching config.
  localparam int DrainCycles = 8;
  localparam int RandomItems = 650;

  // One full set of register values, written together while the block is idle.
  typedef struct {
    logic [drd_pkg::ScoreW-1:0] threshold;
    logic [drd_pkg::ScaleW-1:0] image_width;
    logic [drd_pkg::ScaleW-1:0] image_height;
    logic [drd_pkg::LenW-1:0]   row_length;
    logic                       filter_enable;
    logic [drd_pkg::MaskW-1:0]  class_mask;
  } drd_setting_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [drd_pkg::CfgIdxW-1:0]  cfg_index_i;
  logic [drd_pkg::CfgDataW-1:0] cfg_data_i;
  logic [31:0]                  fail_count;
  logic [31:0]                  pending_dets;

  // When set, neither side inserts idle cycles, so the block runs at full rate.
  bit no_idle = 1'b0;
  int quiet_cycles = 0;

  drd_elem_if elem_ch ();
  drd_det_if  det_ch ();

  detection_row_decode_top #(
    .MAX_CLASSES(64)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .elem_i      (elem_ch),
    .det_o       (det_ch)
  );

  // The scoreboard sees exactly what the block sees and keeps its own prediction.
  drd_scoreboard #(
    .MAX_CLASSES(64)
  ) u_det_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .elem_i       (elem_ch),
    .det_i        (det_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending_dets)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: any accepted word or config write counts as progress.
  always @(posedge clk_i) begin
    if (!rst_ni || (elem_ch.valid && elem_ch.ready) || (det_ch.valid && det_ch.ready) ||
        cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IdleLimit) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Output back-pressure. Before each detection word the sink holds ready low for a
  // random number of cycles, then keeps it high until a word is taken.
  initial begin
    int stall;
    det_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        det_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      det_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!det_ch.valid);
    end
  end

  function automatic drd_setting_t make_setting(
      input logic [drd_pkg::ScoreW-1:0] threshold,
      input logic [drd_pkg::ScaleW-1:0] width,
      input logic [drd_pkg::ScaleW-1:0] height,
      input logic [drd_pkg::LenW-1:0]   row_length,
      input logic                       filter_enable,
      input logic [drd_pkg::MaskW-1:0]  class_mask);
    drd_setting_t s;
    s.threshold     = threshold;
    s.image_width   = width;
    s.image_height  = height;
    s.row_length    = row_length;
    s.filter_enable = filter_enable;
    s.class_mask    = class_mask;
    return s;
  endfunction

  // Image sizes: mostly arbitrary, with the smallest, 8192 and zero mixed in.
  function automatic logic [drd_pkg::ScaleW-1:0] pick_scale();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return drd_pkg::ScaleW'(1);
      2:       return drd_pkg::ScaleW'(8192);
      default: return drd_pkg::ScaleW'($urandom_range(1, 8192));
    endcase
  endfunction

  // Elements per row after the block clamps the length register.
  function automatic int row_elems(input logic [drd_pkg::LenW-1:0] row_length);
    if (int'(row_length) < int'(drd_pkg::ClassBase)) return int'(drd_pkg::ClassBase);
    if (int'(row_length) > int'(drd_pkg::ClassBase) + 64) return int'(drd_pkg::ClassBase) + 64;
    return int'(row_length);
  endfunction

  function automatic drd_setting_t random_setting();
    logic [drd_pkg::ScoreW-1:0] threshold;
    logic [drd_pkg::LenW-1:0]   row_length;
    logic [drd_pkg::MaskW-1:0]  class_mask;
    // Low thresholds keep detections frequent; the extremes still show up.
    case ($urandom_range(0, 5))
      0:       threshold = '0;
      1:       threshold = '1;
      2:       threshold = drd_pkg::ScoreW'($urandom);
      default: threshold = drd_pkg::ScoreW'($urandom_range(0, 16'h4000));
    endcase
    // Short rows most of the time; the full 64-class row and clamped values now and then.
    case ($urandom_range(0, 15))
      0:       row_length = drd_pkg::LenW'($urandom_range(0, 4));
      1:       row_length = drd_pkg::LenW'(69);
      2:       row_length = drd_pkg::LenW'($urandom_range(70, 127));
      default: row_length = drd_pkg::LenW'($urandom_range(5, 12));
    endcase
    case ($urandom_range(0, 3))
      0:       class_mask = '1;
      default: class_mask = {$urandom, $urandom};
    endcase
    return make_setting(threshold, pick_scale(), pick_scale(), row_length,
                        1'($urandom_range(0, 1)), class_mask);
  endfunction

  // Offer one element word, after a random number of idle cycles, and wait until taken.
  // Valid stays high afterwards so that back-to-back words need no extra edge.
  task automatic send_element(input logic [drd_pkg::ElemW-1:0] value);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      elem_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    elem_ch.valid   <= 1'b1;
    elem_ch.element <= value;
    do @(posedge clk_i); while (!elem_ch.ready);
  endtask

  task automatic send_values(input logic [drd_pkg::ElemW-1:0] values [$]);
    foreach (values[i]) send_element(values[i]);
  endtask

  // A row of random content. Confidence and class scores lean high half of the time so
  // that the threshold test passes often enough to exercise the corner arithmetic.
  task automatic send_random_row(input int count);
    logic [drd_pkg::ElemW-1:0] value;
    for (int k = 0; k < count; k++) begin
      if (k >= int'(drd_pkg::ConfPos) && $urandom_range(0, 1) == 0) begin
        value = drd_pkg::ElemW'($urandom_range(16'h8000, 16'hFFFF));
      end else begin
        value = drd_pkg::ElemW'($urandom_range(0, 16'hFFFF));
      end
      send_element(value);
    end
  endtask

  // Drop valid, then wait until every predicted detection has come out and the back end
  // has had time to finish rows that emit nothing.
  task automatic drain_results();
    elem_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_dets != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [drd_pkg::CfgIdxW-1:0] index,
                           input logic [drd_pkg::CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    @(posedge clk_i);
  endtask

  // Registers are written only with the block idle, all six in consecutive cycles.
  task automatic apply_setting(input drd_setting_t s);
    drain_results();
    write_reg(drd_pkg::RegConfThreshold, drd_pkg::CfgDataW'(s.threshold));
    write_reg(drd_pkg::RegImageWidth, drd_pkg::CfgDataW'(s.image_width));
    write_reg(drd_pkg::RegImageHeight, drd_pkg::CfgDataW'(s.image_height));
    write_reg(drd_pkg::RegRowLength, drd_pkg::CfgDataW'(s.row_length));
    write_reg(drd_pkg::RegFilterEnable, drd_pkg::CfgDataW'(s.filter_enable));
    write_reg(drd_pkg::RegClassMask, drd_pkg::CfgDataW'(s.class_mask));
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    drd_setting_t setting;
    int           sent_random;
    int           row_len;
    int           rows;

    cfg_we_i        <= 1'b0;
    cfg_index_i     <= '0;
    cfg_data_i      <= '0;
    elem_ch.valid   <= 1'b0;
    elem_ch.element <= '0;
    rst_ni          <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Image size 8192, a six-element row. The first row puts every field at its extreme:
    // the box reaches past the right and top edges and the score is the largest possible.
    // The second row is all zeros, which still emits because the threshold is zero.
    apply_setting(make_setting('0, drd_pkg::ScaleW'(8192), drd_pkg::ScaleW'(8192),
                               drd_pkg::LenW'(6), 1'b0, '0));
    send_values('{16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    send_values('{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000});

    // A length below the legal range clamps to a row without class scores, and a zero
    // image width collapses the horizontal corners. Class 0 with score 0 is emitted.
    apply_setting(make_setting('0, '0, drd_pkg::ScaleW'(1), drd_pkg::LenW'(0), 1'b0, '0));
    send_values('{16'h8000, 16'h4000, 16'h2000, 16'h1000, 16'h0001});

    // Row length changed in the middle of a row. Classes 0 and 1 tie, so the earlier one
    // must stay best; after the length shrinks, the next element closes the row at once.
    apply_setting(make_setting('0, drd_pkg::ScaleW'(640), drd_pkg::ScaleW'(480),
                               drd_pkg::LenW'(9), 1'b1, 64'h1));
    send_values('{16'h8000, 16'h8000, 16'h4000, 16'h4000, 16'hFFFF, 16'h000A, 16'h000A});
    apply_setting(make_setting('0, drd_pkg::ScaleW'(640), drd_pkg::ScaleW'(480),
                               drd_pkg::LenW'(7), 1'b1, 64'h1));
    send_element(16'h0005);

    // Random phases: a fresh register setting, a burst of whole rows, and now and then a
    // broken row whose tail runs into the next setting.
    sent_random = 0;
    while (sent_random < RandomItems) begin
      setting = random_setting();
      no_idle = ($urandom_range(0, 4) == 0);
      apply_setting(setting);
      row_len = row_elems(setting.row_length);
      rows    = (row_len > 20) ? $urandom_range(1, 2) : $urandom_range(3, 8);
      repeat (rows) send_random_row(row_len);
      sent_random += rows * row_len;
      if ($urandom_range(0, 3) == 0) begin
        rows = $urandom_range(1, row_len - 1);
        send_random_row(rows);
        sent_random += rows;
      end
    end

    drain_results();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
